### sv/iepts_pkg.sv
// ----------------------------------------------------------------------------
// iepts_pkg
// Shared types and constants of the paged EEPROM transfer sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package iepts_pkg;

    localparam int ADDR_W      = 11;
    localparam int CNT_W       = 12;
    localparam int MAX_RES     = 3;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 21;
    localparam int PROD_W      = 32;
    localparam int QUOT_W      = 12;

    localparam logic [ADDR_W-1:0] BLOCK_MASK  = 11'h700;
    localparam int                BLOCK_SHIFT = 7;
    localparam logic [7:0]        BASE_RESET  = 8'd160;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_DEV  = 2'd1;
    localparam logic [1:0] ERR_WORD = 2'd2;
    localparam logic [1:0] ERR_DATA = 2'd3;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DONE  = 2'd1,
        CMD_DATA  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PROBE,
        PH_DEV,
        PH_WORD,
        PH_WAIT_DATA,
        PH_WDATA,
        PH_RDEV,
        PH_RDATA
    } phase_t;

    typedef enum logic [3:0] {
        K_ADDR_TX   = 4'd0,
        K_ADDR_RX   = 4'd1,
        K_SEND      = 4'd2,
        K_RECV_ACK  = 4'd3,
        K_RECV_NACK = 4'd4,
        K_STOP      = 4'd5,
        K_READ      = 4'd6,
        K_NEED      = 4'd7,
        K_DONE      = 4'd8
    } kind_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic              write_op;
        logic [ADDR_W-1:0] start_address;
        logic [CNT_W-1:0]  byte_count;
        logic              ack;
        logic [7:0]        rx_byte;
        logic [7:0]        tx_byte;
    } item_t;

    typedef struct packed {
        logic              valid;
        item_t             item;
        logic [PROD_W-1:0] prod;
    } stage_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] bus_byte;
        logic [7:0] read_data;
        logic [1:0] error_code;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0]                 count;
        result_t [MAX_RES-1:0]      res;
    } push_t;

endpackage

`default_nettype wire

### sv/iepts_in_if.sv
// ----------------------------------------------------------------------------
// iepts_in_if
// Request channel: start requests, bus completions and write data bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface iepts_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic        write_op;
    logic [10:0] start_address;
    logic [11:0] byte_count;
    logic        ack;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;

    modport source (
        output valid, cmd, write_op, start_address, byte_count, ack, rx_byte, tx_byte,
        input  ready
    );
    modport sink (
        input  valid, cmd, write_op, start_address, byte_count, ack, rx_byte, tx_byte,
        output ready
    );
endinterface

`default_nettype wire

### sv/iepts_out_if.sv
// ----------------------------------------------------------------------------
// iepts_out_if
// Result channel: bus operations, read data, data requests and completion.
// ----------------------------------------------------------------------------
`default_nettype none

interface iepts_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [7:0] bus_byte;
    logic [7:0] read_data;
    logic [1:0] error_code;
    logic       last;

    modport source (
        output valid, kind, bus_byte, read_data, error_code, last,
        input  ready
    );
    modport sink (
        input  valid, kind, bus_byte, read_data, error_code, last,
        output ready
    );
endinterface

`default_nettype wire

### sv/i2c_eeprom_paged_transfer_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_paged_transfer_sequencer_unit
// Sequences byte-level I2C master operations for a paged serial EEPROM.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  req      in         cmd, write_op, start_address, byte_count, ack, rx_byte, tx_byte
//  rsp      out        kind, bus_byte, read_data, error_code, last
//  cfg      in         cfg_we, cfg_wdata (device base address)
//
// An item is accepted every cycle while the result queue holds at most one
// entry; with the queue empty, its first result passes the input register and
// enters the result queue before it is offered. The sustained rate is set by
// the one-per-cycle drain of the four-entry result queue while rsp is ready.
// A stalled result channel holds the queue and, once it holds over one entry,
// the input register. Reset is asynchronous and sets the base address to 160.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_eeprom_paged_transfer_sequencer_unit #(
    parameter int PAGE_BYTES   = 16,
    parameter int ADDRESS_BITS = 11
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    iepts_in_if.sink        req,
    iepts_out_if.source     rsp,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata
);

    iepts_pkg::stage_t stage;
    iepts_pkg::push_t  push;
    logic              space_ok;

    iepts_inreg #(
        .PAGE_BYTES   (PAGE_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_inreg (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .space_ok (space_ok),
        .stage    (stage)
    );

    iepts_core #(
        .PAGE_BYTES   (PAGE_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stage     (stage),
        .push      (push)
    );

    iepts_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space_ok (space_ok),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

### sv/iepts_inreg.sv
// ----------------------------------------------------------------------------
// iepts_inreg
// Input register; also registers the reciprocal product of the start address.
// ----------------------------------------------------------------------------
`default_nettype none

module iepts_inreg #(
    parameter int PAGE_BYTES   = 16,
    parameter int ADDRESS_BITS = 11
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    iepts_in_if.sink            req,
    input  wire logic           space_ok,
    output iepts_pkg::stage_t   stage
);

    localparam int AW = iepts_pkg::ADDR_W;
    localparam int PW = iepts_pkg::PROD_W;
    localparam int RECIP =
        ((1 << iepts_pkg::RECIP_SHIFT) + PAGE_BYTES - 1) / PAGE_BYTES;
    localparam logic [AW-1:0] ADDR_MASK = AW'((1 << ADDRESS_BITS) - 1);

    logic                  vld_reg;
    iepts_pkg::item_t      item_reg;
    logic [PW-1:0]         prod_reg;
    logic [PW-1:0]         prod_next;
    logic [AW-1:0]         addr_m;
    logic                  take;
    logic                  fire;

    assign take      = vld_reg && space_ok;
    assign req.ready = !vld_reg || space_ok;
    assign fire      = req.valid && req.ready;
    assign addr_m    = req.start_address & ADDR_MASK;
    assign prod_next = PW'(addr_m) * PW'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (fire)
        begin
            vld_reg <= 1'b1;
        end
        else if (take)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            item_reg.cmd           <= req.cmd;
            item_reg.write_op      <= req.write_op;
            item_reg.start_address <= req.start_address;
            item_reg.byte_count    <= req.byte_count;
            item_reg.ack           <= req.ack;
            item_reg.rx_byte       <= req.rx_byte;
            item_reg.tx_byte       <= req.tx_byte;
            prod_reg               <= prod_next;
        end
    end

    assign stage.valid = take;
    assign stage.item  = item_reg;
    assign stage.prod  = prod_reg;

endmodule

`default_nettype wire

### sv/iepts_core.sv
// ----------------------------------------------------------------------------
// iepts_core
// Transfer state and the decode of one item into up to three results.
// ----------------------------------------------------------------------------
`default_nettype none

module iepts_core #(
    parameter int PAGE_BYTES   = 16,
    parameter int ADDRESS_BITS = 11
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [7:0]     cfg_wdata,
    input  wire iepts_pkg::stage_t stage,
    output iepts_pkg::push_t    push
);

    localparam int AW    = iepts_pkg::ADDR_W;
    localparam int CW    = iepts_pkg::CNT_W;
    localparam int QW    = iepts_pkg::QUOT_W;
    localparam int OFF_W = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam int PBL_W = $clog2(PAGE_BYTES + 1);
    localparam int MW    = 20;

    iepts_pkg::phase_t       phase_reg, phase_next;
    logic                    is_write_reg, is_write_next;
    logic [ADDRESS_BITS-1:0] addr_reg, addr_next;
    logic [OFF_W-1:0]        off_reg, off_next;
    logic [CW-1:0]           bytes_reg, bytes_next;
    logic [PBL_W-1:0]        pbl_reg, pbl_next;
    logic [7:0]              base_reg;

    logic [ADDRESS_BITS-1:0] addr_inc;
    logic [OFF_W-1:0]        off_inc;
    logic [CW-1:0]           bytes_dec;
    logic [PBL_W-1:0]        pbl_dec;
    logic [PBL_W-1:0]        room_cur;
    logic [PBL_W-1:0]        room_inc;
    logic [7:0]              dev_cur;
    logic [7:0]              dev_inc;
    logic [QW-1:0]           quot;
    logic [MW-1:0]           quot_p;
    logic [OFF_W-1:0]        off_start;
    logic [AW-1:0]           addr_start;

    iepts_pkg::result_t      r0, r1, r2;
    logic [1:0]              n;

    function automatic logic [PBL_W-1:0] page_room(input logic [OFF_W-1:0] off,
                                                   input logic [CW-1:0] left);
        logic [PBL_W-1:0] room;
        room = PBL_W'(PAGE_BYTES) - PBL_W'(off);
        if (CW'(room) > left)
        begin
            room = left[PBL_W-1:0];
        end
        return room;
    endfunction

    function automatic logic [7:0] dev_byte(input logic [ADDRESS_BITS-1:0] a,
                                            input logic [7:0] base);
        logic [AW-1:0] blk;
        blk = (AW'(a) & iepts_pkg::BLOCK_MASK) >> iepts_pkg::BLOCK_SHIFT;
        return base | blk[7:0];
    endfunction

    function automatic iepts_pkg::result_t mk(input iepts_pkg::kind_t k,
                                              input logic [7:0] bus,
                                              input logic [7:0] rd,
                                              input logic [1:0] err);
        iepts_pkg::result_t r;
        r.kind       = k;
        r.bus_byte   = bus;
        r.read_data  = rd;
        r.error_code = err;
        r.last       = 1'b0;
        return r;
    endfunction

    assign addr_inc  = addr_reg + 1'b1;
    assign off_inc   = ((addr_inc == '0) ||
                        (PBL_W'(off_reg) + 1'b1 == PBL_W'(PAGE_BYTES))) ? '0
                                                                       : off_reg + 1'b1;
    assign bytes_dec = bytes_reg - 1'b1;
    assign pbl_dec   = pbl_reg - 1'b1;
    assign room_cur  = page_room(off_reg, bytes_reg);
    assign room_inc  = page_room(off_inc, bytes_dec);
    assign dev_cur   = dev_byte(addr_reg, base_reg);
    assign dev_inc   = dev_byte(addr_inc, base_reg);

    assign addr_start = AW'(stage.item.start_address[ADDRESS_BITS-1:0]);
    assign quot       = stage.prod[iepts_pkg::RECIP_SHIFT +: QW];
    assign quot_p     = MW'(quot) * MW'(PAGE_BYTES);
    assign off_start  = OFF_W'(addr_start - quot_p[AW-1:0]);

    always_comb
    begin
        phase_next    = phase_reg;
        is_write_next = is_write_reg;
        addr_next     = addr_reg;
        off_next      = off_reg;
        bytes_next    = bytes_reg;
        pbl_next      = pbl_reg;
        r0 = mk(iepts_pkg::K_ADDR_TX, 8'd0, 8'd0, iepts_pkg::ERR_OK);
        r1 = r0;
        r2 = r0;
        n  = 2'd0;
        if (stage.valid)
        begin
            unique case (stage.item.cmd)
                iepts_pkg::CMD_START:
                begin
                    if (phase_reg == iepts_pkg::PH_IDLE)
                    begin
                        is_write_next = stage.item.write_op;
                        addr_next     = stage.item.start_address[ADDRESS_BITS-1:0];
                        off_next      = off_start;
                        bytes_next    = stage.item.byte_count;
                        pbl_next      = '0;
                        phase_next    = iepts_pkg::PH_PROBE;
                        r0 = mk(iepts_pkg::K_ADDR_TX, base_reg, 8'd0, iepts_pkg::ERR_OK);
                        n  = 2'd1;
                    end
                end
                iepts_pkg::CMD_DATA:
                begin
                    if (phase_reg == iepts_pkg::PH_WAIT_DATA)
                    begin
                        phase_next = iepts_pkg::PH_WDATA;
                        r0 = mk(iepts_pkg::K_SEND, stage.item.tx_byte, 8'd0,
                                iepts_pkg::ERR_OK);
                        n  = 2'd1;
                    end
                end
                iepts_pkg::CMD_DONE:
                begin
                    unique case (phase_reg)
                        iepts_pkg::PH_PROBE:
                        begin
                            r0 = mk(iepts_pkg::K_STOP, 8'd0, 8'd0, iepts_pkg::ERR_OK);
                            n  = 2'd2;
                            if (!stage.item.ack)
                            begin
                                r1 = mk(iepts_pkg::K_ADDR_TX, base_reg, 8'd0,
                                        iepts_pkg::ERR_OK);
                            end
                            else if (bytes_reg == '0)
                            begin
                                phase_next = iepts_pkg::PH_IDLE;
                                r1 = mk(iepts_pkg::K_DONE, 8'd0, 8'd0, iepts_pkg::ERR_OK);
                            end
                            else
                            begin
                                pbl_next   = room_cur;
                                phase_next = iepts_pkg::PH_DEV;
                                r1 = mk(iepts_pkg::K_ADDR_TX, dev_cur, 8'd0,
                                        iepts_pkg::ERR_OK);
                            end
                        end
                        iepts_pkg::PH_DEV, iepts_pkg::PH_WORD, iepts_pkg::PH_WDATA,
                        iepts_pkg::PH_RDEV:
                        begin
                            if (!stage.item.ack)
                            begin
                                phase_next = iepts_pkg::PH_IDLE;
                                r0 = mk(iepts_pkg::K_STOP, 8'd0, 8'd0, iepts_pkg::ERR_OK);
                                n  = 2'd2;
                                if (phase_reg == iepts_pkg::PH_DEV)
                                begin
                                    r1 = mk(iepts_pkg::K_DONE, 8'd0, 8'd0,
                                            iepts_pkg::ERR_DEV);
                                end
                                else if (phase_reg == iepts_pkg::PH_WORD)
                                begin
                                    r1 = mk(iepts_pkg::K_DONE, 8'd0, 8'd0,
                                            iepts_pkg::ERR_WORD);
                                end
                                else
                                begin
                                    r1 = mk(iepts_pkg::K_DONE, 8'd0, 8'd0,
                                            iepts_pkg::ERR_DATA);
                                end
                            end
                            else if (phase_reg == iepts_pkg::PH_DEV)
                            begin
                                phase_next = iepts_pkg::PH_WORD;
                                r0 = mk(iepts_pkg::K_SEND, addr_reg[7:0], 8'd0,
                                        iepts_pkg::ERR_OK);
                                n  = 2'd1;
                            end
                            else if (phase_reg == iepts_pkg::PH_WORD)
                            begin
                                n = 2'd1;
                                if (is_write_reg)
                                begin
                                    phase_next = iepts_pkg::PH_WAIT_DATA;
                                    r0 = mk(iepts_pkg::K_NEED, 8'd0, 8'd0,
                                            iepts_pkg::ERR_OK);
                                end
                                else
                                begin
                                    phase_next = iepts_pkg::PH_RDEV;
                                    r0 = mk(iepts_pkg::K_ADDR_RX, dev_cur, 8'd0,
                                            iepts_pkg::ERR_OK);
                                end
                            end
                            else if (phase_reg == iepts_pkg::PH_WDATA)
                            begin
                                addr_next  = addr_inc;
                                off_next   = off_inc;
                                bytes_next = bytes_dec;
                                pbl_next   = pbl_dec;
                                if (pbl_dec != '0)
                                begin
                                    phase_next = iepts_pkg::PH_WAIT_DATA;
                                    r0 = mk(iepts_pkg::K_NEED, 8'd0, 8'd0,
                                            iepts_pkg::ERR_OK);
                                    n  = 2'd1;
                                end
                                else
                                begin
                                    phase_next = iepts_pkg::PH_PROBE;
                                    r0 = mk(iepts_pkg::K_STOP, 8'd0, 8'd0,
                                            iepts_pkg::ERR_OK);
                                    r1 = mk(iepts_pkg::K_ADDR_TX, base_reg, 8'd0,
                                            iepts_pkg::ERR_OK);
                                    n  = 2'd2;
                                end
                            end
                            else
                            begin
                                phase_next = iepts_pkg::PH_RDATA;
                                n = 2'd1;
                                if (pbl_reg == PBL_W'(1))
                                begin
                                    r0 = mk(iepts_pkg::K_RECV_NACK, 8'd0, 8'd0,
                                            iepts_pkg::ERR_OK);
                                end
                                else
                                begin
                                    r0 = mk(iepts_pkg::K_RECV_ACK, 8'd0, 8'd0,
                                            iepts_pkg::ERR_OK);
                                end
                            end
                        end
                        iepts_pkg::PH_RDATA:
                        begin
                            addr_next  = addr_inc;
                            off_next   = off_inc;
                            bytes_next = bytes_dec;
                            pbl_next   = pbl_dec;
                            r0 = mk(iepts_pkg::K_READ, 8'd0, stage.item.rx_byte,
                                    iepts_pkg::ERR_OK);
                            if (pbl_dec != '0)
                            begin
                                n = 2'd2;
                                if (pbl_dec == PBL_W'(1))
                                begin
                                    r1 = mk(iepts_pkg::K_RECV_NACK, 8'd0, 8'd0,
                                            iepts_pkg::ERR_OK);
                                end
                                else
                                begin
                                    r1 = mk(iepts_pkg::K_RECV_ACK, 8'd0, 8'd0,
                                            iepts_pkg::ERR_OK);
                                end
                            end
                            else
                            begin
                                r1 = mk(iepts_pkg::K_STOP, 8'd0, 8'd0, iepts_pkg::ERR_OK);
                                n  = 2'd3;
                                if (bytes_dec == '0)
                                begin
                                    phase_next = iepts_pkg::PH_IDLE;
                                    r2 = mk(iepts_pkg::K_DONE, 8'd0, 8'd0,
                                            iepts_pkg::ERR_OK);
                                end
                                else
                                begin
                                    pbl_next   = room_inc;
                                    phase_next = iepts_pkg::PH_DEV;
                                    r2 = mk(iepts_pkg::K_ADDR_TX, dev_inc, 8'd0,
                                            iepts_pkg::ERR_OK);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
        r0.last = (n == 2'd1);
        r1.last = (n == 2'd2);
        r2.last = (n == 2'd3);
    end

    assign push.count  = n;
    assign push.res[0] = r0;
    assign push.res[1] = r1;
    assign push.res[2] = r2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= iepts_pkg::PH_IDLE;
            is_write_reg <= 1'b0;
            addr_reg     <= '0;
            off_reg      <= '0;
            bytes_reg    <= '0;
            pbl_reg      <= '0;
            base_reg     <= iepts_pkg::BASE_RESET;
        end
        else
        begin
            phase_reg    <= phase_next;
            is_write_reg <= is_write_next;
            addr_reg     <= addr_next;
            off_reg      <= off_next;
            bytes_reg    <= bytes_next;
            pbl_reg      <= pbl_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

### sv/iepts_resq.sv
// ----------------------------------------------------------------------------
// iepts_resq
// Result queue: takes up to three results a cycle, hands out one a cycle while rsp is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module iepts_resq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire iepts_pkg::push_t push,
    output logic                space_ok,
    iepts_out_if.source         rsp
);

    localparam int PTR_W = iepts_pkg::QPTR_W;
    localparam int CNT_W = iepts_pkg::QCNT_W;

    iepts_pkg::result_t  q_mem [iepts_pkg::QDEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                pop;
    iepts_pkg::result_t  head;

    assign space_ok = cnt_reg <= CNT_W'(iepts_pkg::QDEPTH - iepts_pkg::MAX_RES);
    assign pop      = (cnt_reg != '0) && rsp.ready;
    assign head     = q_mem[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign cnt_next    = cnt_reg + CNT_W'(push.count) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < iepts_pkg::MAX_RES; i++)
        begin
            if (2'(i) < push.count)
            begin
                q_mem[wr_ptr_reg + PTR_W'(i)] <= push.res[i];
            end
        end
    end

    assign rsp.valid      = cnt_reg != '0;
    assign rsp.kind       = head.kind;
    assign rsp.bus_byte   = head.bus_byte;
    assign rsp.read_data  = head.read_data;
    assign rsp.error_code = head.error_code;
    assign rsp.last       = head.last;

endmodule

`default_nettype wire
